/* sv/s2r_pkg.sv */
// Shared types, constants and coefficient table for the spectrum to RGB converter.
package s2r_pkg;

    // Colour-matching table geometry
    localparam int TABLE_DEPTH = 128;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int LIM_W       = (TBL_AW + 1 > 8) ? TBL_AW + 1 : 8;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Datapath widths
    localparam int SUM_W      = 48;
    localparam int W_W        = 18;
    localparam int MP_W       = 35;
    localparam int NUM_W      = 56;
    localparam int XYZ_W      = 33;
    localparam int COEF_W     = 19;
    localparam int MPROD_W    = 52;
    localparam int ACC_W      = 55;
    localparam int RGB_W      = 24;
    localparam int DVD_W      = 64;
    localparam int DVR_W      = 48;
    localparam int SHORT_BITS = 34;

    // sRGB matrix in Q.16
    localparam logic signed [COEF_W-1:0] MTX [3][3] = '{
        '{19'sd212368, -19'sd100739, -19'sd32672},
        '{-19'sd63521, 19'sd122945,  19'sd2723},
        '{19'sd3647,   -19'sd13372,  19'sd69292}
    };

    typedef struct packed {
        logic        opcode;
        logic [6:0]  table_index;
        logic [15:0] wavelength;
        logic [15:0] weight_x;
        logic [15:0] weight_y;
        logic [15:0] weight_z;
        logic [15:0] sample_value;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic signed [23:0] red;
        logic signed [23:0] green;
        logic signed [23:0] blue;
        logic               in_gamut;
        logic               luminance_zero;
    } t_out_item;

    typedef struct packed {
        logic [15:0] lower_wavelength;
        logic [15:0] upper_wavelength;
        logic [7:0]  target_luminance;
        logic [7:0]  table_entries;
    } t_cfg;

    typedef enum logic [1:0] {
        CFG_LOWER   = 2'd0,
        CFG_UPPER   = 2'd1,
        CFG_TARGET  = 2'd2,
        CFG_ENTRIES = 2'd3
    } t_cfg_index;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_ACC,
        CMD_EMIT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op     op;
        logic        emit;
        logic [6:0]  table_index;
        logic [15:0] wavelength;
        logic [15:0] weight_x;
        logic [15:0] weight_y;
        logic [15:0] weight_z;
        logic [15:0] sample_value;
    } t_cmd;

    typedef struct packed {
        logic [15:0] wl;
        logic [15:0] wx;
        logic [15:0] wy;
        logic [15:0] wz;
    } t_entry;

    typedef enum logic [4:0] {
        B_IDLE,
        B_CHK_RD,
        B_CHK,
        B_RD_A,
        B_RD_B,
        B_LAT_B,
        B_I_MUL,
        B_I_DIV,
        B_I_WAIT,
        B_MAC,
        B_ADD,
        B_E_CHK,
        B_E_MUL,
        B_E_DIV,
        B_E_WAIT,
        B_M_MUL,
        B_M_ADD,
        B_M_RND,
        B_PUSH
    } t_back_state;

endpackage

/* sv/s2r_divider.sv */
// Shared bit-serial signed divider, one quotient bit per cycle, truncating toward zero.
module s2r_divider (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_short,
    input  logic signed [s2r_pkg::DVD_W-1:0] i_dividend,
    input  logic signed [s2r_pkg::DVR_W-1:0] i_divisor,
    output logic                             o_done,
    output logic signed [s2r_pkg::DVD_W-1:0] o_quotient
);
    import s2r_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_q;
    logic [DVR_W-1:0] r_rem;
    logic [DVR_W-1:0] r_dvr;
    logic             r_neg;

    logic [DVD_W-1:0] dvd_mag;
    logic [DVR_W-1:0] dvr_mag;
    logic [DVR_W:0]   trial;
    logic             ge;

    // Operand magnitudes and one restoring step
    always_comb begin
        dvd_mag = i_dividend[DVD_W-1] ? DVD_W'(-i_dividend) : DVD_W'(i_dividend);
        dvr_mag = i_divisor[DVR_W-1] ? DVR_W'(-i_divisor) : DVR_W'(i_divisor);
        trial   = {r_rem, r_q[DVD_W-1]};
        ge      = (trial >= {1'b0, r_dvr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_dvr  <= dvr_mag;
                r_neg  <= i_dividend[DVD_W-1] ^ i_divisor[DVR_W-1];
                if (i_short) begin
                    r_q   <= dvd_mag << (DVD_W - SHORT_BITS);
                    r_cnt <= CNT_W'(SHORT_BITS);
                end else begin
                    r_q   <= dvd_mag;
                    r_cnt <= CNT_W'(DVD_W);
                end
            end else if (r_busy) begin
                r_rem <= ge ? DVR_W'(trial - {1'b0, r_dvr}) : trial[DVR_W-1:0];
                r_q   <= {r_q[DVD_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_q) : $signed(r_q);

endmodule

/* sv/s2r_front.sv */
// Front end: accepts items, tracks spectrum framing and issues commands to the queue.
module s2r_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  s2r_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  s2r_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output s2r_pkg::t_cmd     o_cmd
);
    import s2r_pkg::*;

    logic r_summing, n_summing;
    logic r_closed, n_closed;
    logic accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // Classify the item
    always_comb begin
        n_summing         = r_summing;
        n_closed          = r_closed;
        o_push            = 1'b0;
        o_cmd.op          = CMD_LOAD;
        o_cmd.emit        = i_item.last;
        o_cmd.table_index = i_item.table_index;
        o_cmd.wavelength  = i_item.wavelength;
        o_cmd.weight_x    = i_item.weight_x;
        o_cmd.weight_y    = i_item.weight_y;
        o_cmd.weight_z    = i_item.weight_z;
        o_cmd.sample_value = i_item.sample_value;
        if (accept) begin
            if (i_item.opcode == OP_LOAD) begin
                o_push = (LIM_W'(i_item.table_index) < LIM_W'(TABLE_DEPTH));
            end else if (r_closed) begin
                // drop samples until the end of the spectrum
                if (i_item.last) begin
                    n_closed = 1'b0;
                end
            end else if (!r_summing) begin
                if (i_item.wavelength < i_cfg.lower_wavelength) begin
                    if (i_item.last) begin
                        o_push   = 1'b1;
                        o_cmd.op = CMD_EMIT;
                    end
                end else begin
                    o_push    = 1'b1;
                    o_cmd.op  = CMD_ACC;
                    n_summing = !i_item.last;
                end
            end else if (i_item.wavelength >= i_cfg.upper_wavelength) begin
                o_push    = 1'b1;
                o_cmd.op  = CMD_EMIT;
                n_summing = 1'b0;
                n_closed  = !i_item.last;
            end else begin
                o_push    = 1'b1;
                o_cmd.op  = CMD_ACC;
                n_summing = !i_item.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_summing <= 1'b0;
            r_closed  <= 1'b0;
        end else begin
            r_summing <= n_summing;
            r_closed  <= n_closed;
        end
    end

endmodule

/* sv/s2r_queue.sv */
// Short command queue between front and back.
module s2r_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  s2r_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output s2r_pkg::t_cmd o_cmd
);
    import s2r_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command popped from an empty queue");

endmodule

/* sv/s2r_back.sv */
// Back end: table memory, interpolating accumulator, rescale and sRGB matrix sequencer.
module s2r_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  s2r_pkg::t_cfg      i_cfg,
    input  logic               i_cmd_valid,
    input  s2r_pkg::t_cmd      i_cmd,
    output logic               o_cmd_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output s2r_pkg::t_out_item o_out_item
);
    import s2r_pkg::*;

    t_back_state r_state, n_state;

    t_entry r_tbl [TABLE_DEPTH];
    t_entry r_rdata;
    t_entry r_ent_a;
    t_entry r_ent_b;

    logic [TBL_AW-1:0] rd_addr;
    logic [TBL_AW-1:0] wr_addr;
    logic              tbl_we;
    logic              out_load;

    logic [TBL_AW-1:0] r_seg;
    logic [15:0]       r_lam;
    logic [15:0]       r_val;
    logic              r_emit;
    logic [1:0]        r_ch;
    logic [1:0]        r_row;
    logic [1:0]        r_col;

    logic signed [SUM_W-1:0]   r_sum_x, r_sum_y, r_sum_z;
    logic signed [33:0]        r_iprod;
    logic signed [16:0]        r_dl;
    logic signed [W_W-1:0]     r_w;
    logic signed [MP_W-1:0]    r_mp;
    logic signed [NUM_W-1:0]   r_num;
    logic signed [XYZ_W-1:0]   r_xr, r_zr;
    logic signed [MPROD_W-1:0] r_mprod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [RGB_W-1:0]   r_red, r_green, r_blue;
    logic                      r_lz;
    logic                      r_out_valid;
    t_out_item                 r_out;

    // Divider hookup
    logic                    div_start;
    logic                    div_short;
    logic signed [DVD_W-1:0] div_dividend;
    logic signed [DVR_W-1:0] div_divisor;
    logic                    div_done;
    logic signed [DVD_W-1:0] div_q;

    // Combinational datapath terms
    logic [LIM_W-1:0]          ent, n_lim, n_m2;
    logic                      idx_ok;
    logic [15:0]               v1, v2;
    logic signed [16:0]        dlam, dv, dl;
    logic signed [33:0]        iprod_full;
    logic signed [35:0]        w_sum;
    logic signed [W_W-1:0]     w_new;
    logic signed [MP_W-1:0]    mp_full;
    logic signed [SUM_W-1:0]   sum_sel;
    logic signed [SUM_W:0]     sum_add;
    logic signed [SUM_W-1:0]   sum_new;
    logic signed [SUM_W-1:0]   esel;
    logic signed [NUM_W:0]     num_full;
    logic signed [XYZ_W-1:0]   xyz_new;
    logic signed [XYZ_W-1:0]   xyz_sel;
    logic signed [MPROD_W-1:0] mprod_full;
    logic signed [ACC_W-1:0]   acc_rnd;
    logic signed [ACC_W-1:0]   acc_sh;
    logic signed [RGB_W-1:0]   c_new;
    logic                      gamut;

    s2r_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_short    (div_short),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Table size clamp and load address check
    always_comb begin
        ent = LIM_W'(i_cfg.table_entries);
        if (ent < LIM_W'(2)) begin
            n_lim = LIM_W'(2);
        end else if (ent > LIM_W'(TABLE_DEPTH)) begin
            n_lim = LIM_W'(TABLE_DEPTH);
        end else begin
            n_lim = ent;
        end
        n_m2    = n_lim - LIM_W'(2);
        idx_ok  = (LIM_W'(i_cmd.table_index) < LIM_W'(TABLE_DEPTH));
        wr_addr = TBL_AW'(i_cmd.table_index);
    end

    // Interpolation and accumulate terms
    always_comb begin
        case (r_ch)
            2'd0: begin
                v1 = r_ent_a.wx;
                v2 = r_ent_b.wx;
            end
            2'd1: begin
                v1 = r_ent_a.wy;
                v2 = r_ent_b.wy;
            end
            default: begin
                v1 = r_ent_a.wz;
                v2 = r_ent_b.wz;
            end
        endcase
        dlam       = $signed({1'b0, r_lam}) - $signed({1'b0, r_ent_a.wl});
        dv         = $signed({1'b0, v2}) - $signed({1'b0, v1});
        dl         = $signed({1'b0, r_ent_b.wl}) - $signed({1'b0, r_ent_a.wl});
        iprod_full = dlam * dv;
        w_sum      = $signed({20'd0, v1}) + $signed(div_q[35:0]);
        if (w_sum > 36'sd131071) begin
            w_new = 18'sd131071;
        end else if (w_sum < -36'sd131072) begin
            w_new = -18'sd131072;
        end else begin
            w_new = w_sum[W_W-1:0];
        end
        mp_full = r_w * $signed({1'b0, r_val});
        case (r_ch)
            2'd0:    sum_sel = r_sum_x;
            2'd1:    sum_sel = r_sum_y;
            default: sum_sel = r_sum_z;
        endcase
        sum_add = $signed({sum_sel[SUM_W-1], sum_sel})
                + $signed({{(SUM_W + 1 - MP_W){r_mp[MP_W-1]}}, r_mp});
        if (sum_add > $signed({2'b00, {(SUM_W - 1){1'b1}}})) begin
            sum_new = {1'b0, {(SUM_W - 1){1'b1}}};
        end else if (sum_add < $signed({2'b11, {(SUM_W - 1){1'b0}}})) begin
            sum_new = {1'b1, {(SUM_W - 1){1'b0}}};
        end else begin
            sum_new = sum_add[SUM_W-1:0];
        end
    end

    // Rescale and matrix terms
    always_comb begin
        esel     = (r_ch == 2'd0) ? r_sum_x : r_sum_z;
        num_full = esel * $signed({1'b0, i_cfg.target_luminance});
        if (div_q >= 64'sd2147483648) begin
            xyz_new = 33'sd2147483647;
        end else if (div_q <= -64'sd2147483904) begin
            xyz_new = -33'sd2147483647;
        end else begin
            xyz_new = div_q[XYZ_W-1:0];
        end
        case (r_col)
            2'd0:    xyz_sel = r_xr;
            2'd1:    xyz_sel = $signed({17'd0, i_cfg.target_luminance, 8'd0});
            default: xyz_sel = r_zr;
        endcase
        mprod_full = MTX[r_row][r_col] * xyz_sel;
        acc_rnd    = r_acc + 55'sd32768;
        acc_sh     = acc_rnd >>> 16;
        if (acc_sh > 55'sd8388607) begin
            c_new = 24'sd8388607;
        end else if (acc_sh < -55'sd8388608) begin
            c_new = -24'sd8388608;
        end else begin
            c_new = acc_sh[RGB_W-1:0];
        end
        gamut = !r_lz && (r_red < 24'sd65280) && (r_green < 24'sd65280)
                && (r_blue < 24'sd65280);
    end

    // Divider operand select
    always_comb begin
        div_short = (r_state == B_I_DIV);
        div_start = ((r_state == B_I_DIV) && (r_dl != '0)) || (r_state == B_E_DIV);
        if (r_state == B_I_DIV) begin
            div_dividend = $signed({{(DVD_W - 34){r_iprod[33]}}, r_iprod});
            div_divisor  = $signed({{(DVR_W - 17){r_dl[16]}}, r_dl});
        end else begin
            div_dividend = $signed({r_num, 8'd0});
            div_divisor  = r_sum_y;
        end
    end

    // Sequencer next state and strobes
    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        rd_addr   = r_seg;
        tbl_we    = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        CMD_LOAD: begin
                            tbl_we  = idx_ok;
                            n_state = B_IDLE;
                        end
                        CMD_ACC:  n_state = B_CHK_RD;
                        CMD_EMIT: n_state = B_E_CHK;
                        default:  n_state = B_IDLE;
                    endcase
                end
            end
            B_CHK_RD: begin
                rd_addr = r_seg + 1'b1;
                n_state = B_CHK;
            end
            B_CHK: n_state = B_RD_A;
            B_RD_A: begin
                rd_addr = r_seg;
                n_state = B_RD_B;
            end
            B_RD_B: begin
                rd_addr = r_seg + 1'b1;
                n_state = B_LAT_B;
            end
            B_LAT_B: n_state = B_I_MUL;
            B_I_MUL: n_state = B_I_DIV;
            B_I_DIV: n_state = (r_dl == '0) ? B_MAC : B_I_WAIT;
            B_I_WAIT: begin
                if (div_done) begin
                    n_state = B_MAC;
                end
            end
            B_MAC: n_state = B_ADD;
            B_ADD: begin
                if (r_ch == 2'd2) begin
                    n_state = r_emit ? B_E_CHK : B_IDLE;
                end else begin
                    n_state = B_I_MUL;
                end
            end
            B_E_CHK: n_state = (r_sum_y == '0) ? B_PUSH : B_E_MUL;
            B_E_MUL: n_state = B_E_DIV;
            B_E_DIV: n_state = B_E_WAIT;
            B_E_WAIT: begin
                if (div_done) begin
                    n_state = (r_ch == 2'd1) ? B_M_MUL : B_E_MUL;
                end
            end
            B_M_MUL: n_state = B_M_ADD;
            B_M_ADD: n_state = (r_col == 2'd2) ? B_M_RND : B_M_MUL;
            B_M_RND: n_state = (r_row == 2'd2) ? B_PUSH : B_M_MUL;
            B_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Table memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl[wr_addr] <= '{wl: i_cmd.wavelength, wx: i_cmd.weight_x,
                                wy: i_cmd.weight_y, wz: i_cmd.weight_z};
        end
        r_rdata <= r_tbl[rd_addr];
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg   <= '0;
            r_sum_x <= '0;
            r_sum_y <= '0;
            r_sum_z <= '0;
            r_ch    <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_emit  <= 1'b0;
            r_lz    <= 1'b0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (i_cmd_valid && (i_cmd.op == CMD_ACC)) begin
                        r_lam  <= i_cmd.wavelength;
                        r_val  <= i_cmd.sample_value;
                        r_emit <= i_cmd.emit;
                        if (LIM_W'(r_seg) > n_m2) begin
                            r_seg <= n_m2[TBL_AW-1:0];
                        end
                    end
                end
                B_CHK: begin
                    // step to the next segment once the sample passes its right end
                    if ((r_lam > r_rdata.wl) && ((LIM_W'(r_seg) + LIM_W'(2)) < n_lim)) begin
                        r_seg <= r_seg + 1'b1;
                    end
                end
                B_RD_B: r_ent_a <= r_rdata;
                B_LAT_B: begin
                    r_ent_b <= r_rdata;
                    r_ch    <= '0;
                end
                B_I_MUL: begin
                    r_iprod <= iprod_full;
                    r_dl    <= dl;
                end
                B_I_DIV: begin
                    if (r_dl == '0) begin
                        r_w <= $signed({2'b00, v1});
                    end
                end
                B_I_WAIT: begin
                    if (div_done) begin
                        r_w <= w_new;
                    end
                end
                B_MAC: r_mp <= mp_full;
                B_ADD: begin
                    case (r_ch)
                        2'd0:    r_sum_x <= sum_new;
                        2'd1:    r_sum_y <= sum_new;
                        default: r_sum_z <= sum_new;
                    endcase
                    r_ch <= r_ch + 1'b1;
                end
                B_E_CHK: begin
                    r_ch <= '0;
                    if (r_sum_y == '0) begin
                        r_red   <= '0;
                        r_green <= '0;
                        r_blue  <= '0;
                        r_lz    <= 1'b1;
                    end else begin
                        r_lz <= 1'b0;
                    end
                end
                B_E_MUL: r_num <= num_full[NUM_W-1:0];
                B_E_WAIT: begin
                    if (div_done) begin
                        if (r_ch == 2'd0) begin
                            r_xr <= xyz_new;
                            r_ch <= 2'd1;
                        end else begin
                            r_zr  <= xyz_new;
                            r_row <= '0;
                            r_col <= '0;
                            r_acc <= '0;
                        end
                    end
                end
                B_M_MUL: r_mprod <= mprod_full;
                B_M_ADD: begin
                    r_acc <= r_acc + ACC_W'(r_mprod);
                    r_col <= r_col + 1'b1;
                end
                B_M_RND: begin
                    case (r_row)
                        2'd0:    r_red   <= c_new;
                        2'd1:    r_green <= c_new;
                        default: r_blue  <= c_new;
                    endcase
                    r_acc <= '0;
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end
                B_PUSH: begin
                    if (out_load) begin
                        r_sum_x <= '0;
                        r_sum_y <= '0;
                        r_sum_z <= '0;
                        r_seg   <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.red            <= r_red;
            r_out.green          <= r_green;
            r_out.blue           <= r_blue;
            r_out.in_gamut       <= gamut;
            r_out.luminance_zero <= r_lz;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == B_I_WAIT || r_state == B_E_WAIT))
        else $error("divider finished outside a wait state");

    a_result_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == B_PUSH)
        else $error("result appeared without a push");

    a_zero_luminance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.luminance_zero) |->
            (r_out.red == '0 && r_out.green == '0 && r_out.blue == '0 && !r_out.in_gamut))
        else $error("zero luminance result carries a colour");

endmodule

/* sv/spectrum_to_rgb_converter_unit.sv */
// Top level of the spectrum to RGB converter: config registers, front, queue and back.
//
// Load items write one colour-matching table entry from the idle state of the back
// end. A spectrum sample takes three table reads and, per channel, one interpolation
// divide in the shared bit-serial divider (skipped when both entries share a
// wavelength) plus a multiply-accumulate. Closing a spectrum takes two rescale
// divides in the same divider and nine sequential matrix products, unless luminance
// is zero. The front end takes a new item whenever the two-entry command queue has
// room; items that cause no work are dropped. Results wait in an output register.
module spectrum_to_rgb_converter_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  s2r_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output s2r_pkg::t_out_item o_out_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import s2r_pkg::*;

    t_cfg r_cfg;
    logic q_push, q_full, q_valid, q_pop;
    t_cmd front_cmd, q_cmd;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lower_wavelength <= 16'd24320;
            r_cfg.upper_wavelength <= 16'd52800;
            r_cfg.target_luminance <= 8'd100;
            r_cfg.table_entries    <= 8'd90;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_LOWER:   r_cfg.lower_wavelength <= i_cfg_data;
                CFG_UPPER:   r_cfg.upper_wavelength <= i_cfg_data;
                CFG_TARGET:  r_cfg.target_luminance <= i_cfg_data[7:0];
                CFG_ENTRIES: r_cfg.table_entries    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    s2r_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_cmd   (front_cmd)
    );

    s2r_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd)
    );

    s2r_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
